FILE: rtl/core/ps2dec_pkg.sv
// Shared types and constants for the PS/2 set 2 scan code decoder.
// No dependencies.
`default_nettype none
package ps2dec_pkg;

    localparam int MAP_ROWS_DEF = 32;

    localparam logic [7:0] CODE_E0    = 8'hE0;
    localparam logic [7:0] CODE_F0    = 8'hF0;
    localparam logic [7:0] CODE_E1    = 8'hE1;
    localparam logic [7:0] CODE_F7    = 8'h83;
    localparam logic [7:0] CODE_PRTSC = 8'h84;
    localparam logic [7:0] CODE_BAT   = 8'hAA;
    localparam logic [7:0] CODE_FAIL  = 8'hFC;
    localparam logic [7:0] CODE_CTRL  = 8'h14;
    localparam logic [7:0] CODE_NUM   = 8'h77;
    localparam logic [7:0] CODE_SCRL  = 8'h7E;
    localparam logic [7:0] CODE_LSH   = 8'h12;
    localparam logic [7:0] CODE_RSH   = 8'h59;

    localparam logic [7:0] POS_F7    = 8'h83;
    localparam logic [7:0] POS_PRTSC = 8'hFC;
    localparam logic [7:0] POS_PAUSE = 8'hFE;

    typedef enum logic [3:0] {
        ST_IDLE, ST_F0, ST_E0, ST_E0F0,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
        ST_C1, ST_C2, ST_C3
    } dec_state_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_MAKE  = 2'd1,
        OP_BREAK = 2'd2,
        OP_CLEAR = 2'd3
    } key_op_t;

    typedef enum logic [1:0] {
        ST_RES_NONE = 2'd0,
        ST_RES_PASS = 2'd1,
        ST_RES_FAIL = 2'd2
    } self_test_t;

    // Classified command handed from the decoder to the key map.
    typedef struct packed {
        key_op_t    op;
        logic [7:0] pos;
        logic       bad;
        self_test_t st;
        logic [4:0] qrow;
        logic [2:0] qcol;
    } key_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/ps2dec_front.sv
// Front end: set 2 state machine turning bytes into key map commands.
// Depends on ps2dec_pkg.
`default_nettype none
module ps2dec_front
    import ps2dec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] rx_byte,
    input  wire logic       rx_error,
    input  wire logic [4:0] query_row,
    input  wire logic [2:0] query_col,
    output key_cmd_t        cmd
);

    dec_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else if (take && !rx_error)
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = ST_IDLE;
        case (state_reg)
            ST_IDLE:
                if (rx_byte == CODE_E0) state_next = ST_E0;
                else if (rx_byte == CODE_F0) state_next = ST_F0;
                else if (rx_byte == CODE_E1) state_next = ST_P1;
            ST_E0:
                if (rx_byte == CODE_SCRL) state_next = ST_C1;
                else if (rx_byte == CODE_F0) state_next = ST_E0F0;
            ST_F0:  if (rx_byte == CODE_F0) state_next = ST_F0;
            ST_P1:  if (rx_byte == CODE_CTRL) state_next = ST_P2;
            ST_P2:  if (rx_byte == CODE_NUM) state_next = ST_P3;
            ST_P3:  if (rx_byte == CODE_E1) state_next = ST_P4;
            ST_P4:  if (rx_byte == CODE_F0) state_next = ST_P5;
            ST_P5:  if (rx_byte == CODE_CTRL) state_next = ST_P6;
            ST_P6:  if (rx_byte == CODE_F0) state_next = ST_P7;
            ST_C1:  if (rx_byte == CODE_E0) state_next = ST_C2;
            ST_C2:  if (rx_byte == CODE_F0) state_next = ST_C3;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.qrow = query_row;
        cmd.qcol = query_col;
        if (!rx_error)
        begin
            case (state_reg)
                ST_IDLE:
                    if (rx_byte == CODE_E0 || rx_byte == CODE_F0 || rx_byte == CODE_E1)
                        cmd.op = OP_NONE;
                    else if (rx_byte == CODE_F7)
                    begin
                        cmd.op = OP_MAKE; cmd.pos = POS_F7;
                    end
                    else if (rx_byte == CODE_PRTSC)
                    begin
                        cmd.op = OP_MAKE; cmd.pos = POS_PRTSC;
                    end
                    else if (rx_byte == 8'h00)
                        cmd.op = OP_CLEAR;
                    else if (rx_byte == CODE_BAT)
                        cmd.st = ST_RES_PASS;
                    else if (rx_byte == CODE_FAIL)
                        cmd.st = ST_RES_FAIL;
                    else if (!rx_byte[7])
                    begin
                        cmd.op = OP_MAKE; cmd.pos = rx_byte;
                    end
                    else
                    begin
                        cmd.op = OP_CLEAR; cmd.bad = 1'b1;
                    end
                ST_E0:
                    if (rx_byte == CODE_LSH || rx_byte == CODE_RSH || rx_byte == CODE_SCRL
                        || rx_byte == CODE_F0)
                        cmd.op = OP_NONE;
                    else if (!rx_byte[7])
                    begin
                        cmd.op = OP_MAKE; cmd.pos = {1'b1, rx_byte[6:0]};
                    end
                    else
                    begin
                        cmd.op = OP_CLEAR; cmd.bad = 1'b1;
                    end
                ST_F0:
                    if (rx_byte == CODE_F7)
                    begin
                        cmd.op = OP_BREAK; cmd.pos = POS_F7;
                    end
                    else if (rx_byte == CODE_PRTSC)
                    begin
                        cmd.op = OP_BREAK; cmd.pos = POS_PRTSC;
                    end
                    else if (!rx_byte[7])
                    begin
                        cmd.op = OP_BREAK; cmd.pos = rx_byte;
                    end
                    else
                    begin
                        cmd.op = OP_CLEAR; cmd.bad = 1'b1;
                    end
                ST_E0F0:
                    if (rx_byte == CODE_LSH || rx_byte == CODE_RSH)
                        cmd.op = OP_NONE;
                    else if (!rx_byte[7])
                    begin
                        cmd.op = OP_BREAK; cmd.pos = {1'b1, rx_byte[6:0]};
                    end
                    else
                    begin
                        cmd.op = OP_CLEAR; cmd.bad = 1'b1;
                    end
                ST_P7:
                    if (rx_byte == CODE_NUM)
                    begin
                        cmd.op = OP_MAKE; cmd.pos = POS_PAUSE;
                    end
                ST_C3:
                    if (rx_byte == CODE_SCRL)
                    begin
                        cmd.op = OP_MAKE; cmd.pos = POS_PAUSE;
                    end
                default: cmd.op = OP_NONE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ps2dec_queue.sv
// Two-entry command queue between decoder front and key map back end.
// Depends on ps2dec_pkg.
`default_nettype none
module ps2dec_queue
    import ps2dec_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  key_cmd_t  push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output key_cmd_t  head
);

    key_cmd_t   slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wptr_reg] <= push_cmd;
    end

    assign full      = cnt_reg[1];
    assign not_empty = cnt_reg != 2'd0;
    assign head      = slot_reg[rptr_reg];

endmodule
`default_nettype wire

FILE: rtl/core/ps2dec_back.sv
// Back end: key map, pressed count and registered result beat.
// Depends on ps2dec_pkg.
`default_nettype none
module ps2dec_back
    import ps2dec_pkg::*;
#(
    parameter int MAP_ROWS = MAP_ROWS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  key_cmd_t        cmd,
    output logic            cmd_pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            pause_released,
    output logic [1:0]      key_event,
    output logic [7:0]      key_position,
    output logic            map_changed,
    output logic [1:0]      self_test,
    output logic            bad_code,
    output logic [7:0]      row_bits,
    output logic            query_key_on,
    output logic [8:0]      pressed_count
);

    localparam int RW = $clog2(MAP_ROWS);

    logic [7:0] map_reg [MAP_ROWS];
    logic [7:0] map_next [MAP_ROWS];
    logic [8:0] total_reg, total_next;
    logic       ov_reg;
    logic       pr_reg;
    logic [1:0] ev_reg;
    logic [7:0] pos_reg;
    logic       chg_reg, bad_reg;
    logic [1:0] st_reg;
    logic [7:0] row_reg;
    logic       qk_reg;

    logic       pause_on, hit, chg;
    logic [RW-1:0] prow, krow;
    logic [7:0] rowv;

    assign cmd_pop = cmd_valid && (!ov_reg || !out_stall);
    assign prow    = RW'(POS_PAUSE >> 3);
    assign krow    = RW'(cmd.pos >> 3);

    always_comb
    begin
        for (int i = 0; i < MAP_ROWS; i++)
            map_next[i] = map_reg[i];
        total_next = total_reg;
        chg        = 1'b0;
        pause_on   = map_reg[prow][POS_PAUSE[2:0]];
        if (pause_on)
        begin
            map_next[prow][POS_PAUSE[2:0]] = 1'b0;
            total_next = total_next - 9'd1;
            chg        = 1'b1;
        end
        hit = map_next[krow][cmd.pos[2:0]];
        case (cmd.op)
            OP_MAKE:
                if (!hit)
                begin
                    map_next[krow][cmd.pos[2:0]] = 1'b1;
                    total_next = total_next + 9'd1;
                    chg        = 1'b1;
                end
            OP_BREAK:
                if (hit)
                begin
                    map_next[krow][cmd.pos[2:0]] = 1'b0;
                    total_next = total_next - 9'd1;
                    chg        = 1'b1;
                end
            OP_CLEAR:
            begin
                if (total_next != 9'd0) chg = 1'b1;
                for (int i = 0; i < MAP_ROWS; i++)
                    map_next[i] = '0;
                total_next = '0;
            end
            default: ;
        endcase
        rowv = map_next[RW'(cmd.qrow)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_ROWS; i++)
                map_reg[i] <= '0;
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                for (int i = 0; i < MAP_ROWS; i++)
                    map_reg[i] <= map_next[i];
                total_reg <= total_next;
                ov_reg    <= 1'b1;
            end
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            pr_reg  <= pause_on;
            ev_reg  <= cmd.op;
            pos_reg <= (cmd.op == OP_MAKE || cmd.op == OP_BREAK) ? cmd.pos : 8'h00;
            chg_reg <= chg;
            bad_reg <= cmd.bad;
            st_reg  <= cmd.st;
            row_reg <= rowv;
            qk_reg  <= rowv[cmd.qcol];
        end
    end

    assign out_valid      = ov_reg;
    assign pause_released = pr_reg;
    assign key_event      = ev_reg;
    assign key_position   = pos_reg;
    assign map_changed    = chg_reg;
    assign self_test      = st_reg;
    assign bad_code       = bad_reg;
    assign row_bits       = row_reg;
    assign query_key_on   = qk_reg;
    assign pressed_count  = total_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= 9'd256)
        else $error("pressed count out of range");
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.op == OP_CLEAR |=> total_reg == 9'd0)
        else $error("count not zero after clear");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(total_reg))
        else $error("result lost under stall");

endmodule
`default_nettype wire

FILE: rtl/core/ps2_set2_scan_decoder.sv
// PS/2 set 2 scan decoder top: front decoder, command queue, key map back end.
// Path: an accepted beat is written into the queue, then into the result regs when popped.
// Throughput: one beat per cycle; input stalls only when the 2-entry queue fills.
// Reset: decoder idle, key map and pressed count cleared, no result pending.
// Depends on ps2dec_pkg, ps2dec_front, ps2dec_queue, ps2dec_back.
`default_nettype none
module ps2_set2_scan_decoder
    import ps2dec_pkg::*;
#(
    parameter int MAP_ROWS = MAP_ROWS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       rx_error,
    input  wire logic [4:0] query_row,
    input  wire logic [2:0] query_col,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            pause_released,
    output logic [1:0]      key_event,
    output logic [7:0]      key_position,
    output logic            map_changed,
    output logic [1:0]      self_test,
    output logic            bad_code,
    output logic [7:0]      row_bits,
    output logic            query_key_on,
    output logic [8:0]      pressed_count
);

    key_cmd_t fcmd, hcmd;
    logic     full, ne, pop, take;

    assign in_stall = full;
    assign take     = in_valid && !full;

    ps2dec_front u_front (
        .clk, .rst_n, .take, .rx_byte, .rx_error, .query_row, .query_col, .cmd(fcmd)
    );

    ps2dec_queue u_queue (
        .clk, .rst_n, .push(take), .push_cmd(fcmd), .full,
        .pop, .not_empty(ne), .head(hcmd)
    );

    ps2dec_back #(.MAP_ROWS(MAP_ROWS)) u_back (
        .clk, .rst_n, .cmd_valid(ne), .cmd(hcmd), .cmd_pop(pop),
        .out_valid, .out_stall, .pause_released, .key_event, .key_position,
        .map_changed, .self_test, .bad_code, .row_bits, .query_key_on, .pressed_count
    );

endmodule
`default_nettype wire
